// ----- hdl/rnbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Ringtone note bit packer package
// Shared types, constants and conversion functions for the note bit packer.
// ----------------------------------------------------------------------------
package rnbp_pkg;

   // Item kinds on the request channel. The fourth code means nothing.
   localparam logic [1:0] KindStart  = 2'd0;
   localparam logic [1:0] KindNote   = 2'd1;
   localparam logic [1:0] KindFinish = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CsrDefaultDuration = 3'd0;
   localparam logic [2:0] CsrDefaultOctave   = 3'd1;
   localparam logic [2:0] CsrTempoBpm        = 3'd2;
   localparam logic [2:0] CsrOctaveUp        = 3'd3;
   localparam logic [2:0] CsrVolumeLevel     = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [5:0] DurationReset = 6'd4;
   localparam logic [2:0] OctaveReset   = 3'd6;
   localparam logic [9:0] BpmReset      = 10'd63;
   localparam logic [3:0] VolumeReset   = 4'd7;

   // Instruction opcodes.
   localparam logic [2:0] OpNote   = 3'd1;
   localparam logic [2:0] OpOctave = 3'd2;
   localparam logic [2:0] OpStyle  = 3'd3;
   localparam logic [2:0] OpTempo  = 3'd4;
   localparam logic [2:0] OpVolume = 3'd5;

   // Depth of the queue between front and back.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [9:0] BpmTable [32] = '{
      10'd25,  10'd28,  10'd31,  10'd35,  10'd40,  10'd45,  10'd50,  10'd56,
      10'd63,  10'd70,  10'd80,  10'd90,  10'd100, 10'd112, 10'd125, 10'd140,
      10'd160, 10'd180, 10'd200, 10'd225, 10'd250, 10'd285, 10'd320, 10'd355,
      10'd400, 10'd450, 10'd500, 10'd565, 10'd635, 10'd715, 10'd800, 10'd900
   };

   localparam logic [3:0] LetterTone [8] = '{
      4'd0, 4'd10, 4'd12, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8
   };

   // One queue entry: the bytes completed by one transaction, first byte in
   // slot zero, their count (one to three) and the tally after the item.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      nbytes;
      logic [7:0]      tally;
   } rnbp_entry_type;

   // Nearest table entry; a value midway between two entries takes the
   // higher one, which is the number of midpoints at or below the value.
   function automatic logic [4:0] beat_code(input logic [9:0] bpm);
      logic [4:0]  code;
      logic [10:0] twice;
      code  = '0;
      twice = {bpm, 1'b0};
      for (int i = 0; i < 31; i++) begin
         if (twice >= 11'(BpmTable[i]) + 11'(BpmTable[i + 1])) begin
            code = code + 5'd1;
         end
      end
      return code;
   endfunction

   function automatic logic [2:0] duration_code(input logic [5:0] den);
      logic [2:0] code;
      unique case (den)
         6'd1:    code = 3'd0;
         6'd2:    code = 3'd1;
         6'd4:    code = 3'd2;
         6'd8:    code = 3'd3;
         6'd16:   code = 3'd4;
         6'd32:   code = 3'd5;
         default: code = den[2:0];
      endcase
      return code;
   endfunction

endpackage

// ----- hdl/rnbp_front.sv -----
// ----------------------------------------------------------------------------
// Ringtone note bit packer front end
// Accepts items, builds their instruction bits, merges them with the partial
// byte and hands every group of completed bytes to the queue.
// ----------------------------------------------------------------------------
module rnbp_front import rnbp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [2:0]     csr_index,
   input  logic [9:0]     csr_wdata,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [1:0]     req_kind,
   input  logic [2:0]     req_note_letter,
   input  logic           req_sharp,
   input  logic           req_duration_given,
   input  logic [5:0]     req_duration,
   input  logic           req_octave_given,
   input  logic [2:0]     req_octave,
   input  logic           req_dotted,
   input  logic           q_full,
   output logic           q_push,
   output rnbp_entry_type q_entry
);

   logic [5:0] def_duration_ff;
   logic [2:0] def_octave_ff;
   logic [4:0] beat_code_ff;
   logic       octave_up_ff;
   logic [3:0] volume_ff;

   logic [7:0] partial_ff, partial_in;
   logic [2:0] fill_ff, fill_in;
   logic [2:0] cur_oct_ff, cur_oct_in;
   logic       known_ff, known_in;
   logic [7:0] tally_ff, tally_in;

   logic        accept;
   logic        kind_ok;
   logic [19:0] chunk;
   logic [4:0]  len;
   logic [1:0]  inc;
   logic [2:0]  oct;
   logic [1:0]  oct_field;
   logic [11:0] note_bits;
   logic [4:0]  total;
   logic [31:0] acc;
   logic [8:0]  tally_sum;

   // The tempo code is worked out when the register is written.
   always_ff @(posedge clock) begin
      if (reset) begin
         def_duration_ff <= DurationReset;
         def_octave_ff   <= OctaveReset;
         beat_code_ff    <= beat_code(BpmReset);
         octave_up_ff    <= 1'b0;
         volume_ff       <= VolumeReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrDefaultDuration: def_duration_ff <= csr_wdata[5:0];
            CsrDefaultOctave:   def_octave_ff   <= csr_wdata[2:0];
            CsrTempoBpm:        beat_code_ff    <= beat_code(csr_wdata);
            CsrOctaveUp:        octave_up_ff    <= csr_wdata[0];
            CsrVolumeLevel:     volume_ff       <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      oct       = req_octave_given ? req_octave : def_octave_ff;
      oct_field = 2'(oct + {2'b00, octave_up_ff} + 3'd3);
      note_bits = {OpNote,
                   4'(LetterTone[req_note_letter] + {3'b000, req_sharp}),
                   duration_code(req_duration_given ? req_duration : def_duration_ff),
                   {1'b0, req_dotted}};
      chunk      = '0;
      len        = '0;
      inc        = '0;
      kind_ok    = 1'b0;
      cur_oct_in = cur_oct_ff;
      known_in   = known_ff;
      unique case (req_kind)
         KindStart: begin
            kind_ok  = 1'b1;
            chunk    = {OpTempo, beat_code_ff, OpStyle, 2'b00, OpVolume, volume_ff};
            len      = 5'd20;
            inc      = 2'd3;
            known_in = 1'b0;
         end
         KindNote: begin
            kind_ok    = 1'b1;
            cur_oct_in = oct;
            known_in   = 1'b1;
            if (!known_ff || cur_oct_ff != oct) begin
               chunk = {OpOctave, oct_field, note_bits, 3'b000};
               len   = 5'd17;
               inc   = 2'd2;
            end else begin
               chunk = {note_bits, 8'h00};
               len   = 5'd12;
               inc   = 2'd1;
            end
         end
         KindFinish: begin
            // Zero bits up to the next boundary and then one whole zero byte.
            kind_ok = 1'b1;
            len     = (fill_ff == 3'd0) ? 5'd8 : 5'd16 - {2'b00, fill_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      total     = {2'b00, fill_ff} + len;
      acc       = {partial_ff, 24'h000000} | ({chunk, 12'h000} >> fill_ff);
      tally_sum = {1'b0, tally_ff} + {7'b0000000, inc};
      tally_in  = tally_sum[8] ? 8'hFF : tally_sum[7:0];
      fill_in   = total[2:0];
      unique case (total[4:3])
         2'd0: partial_in = acc[31:24];
         2'd1: partial_in = acc[23:16];
         2'd2: partial_in = acc[15:8];
         2'd3: partial_in = acc[7:0];
      endcase
      q_entry.bytes[0] = acc[31:24];
      q_entry.bytes[1] = acc[23:16];
      q_entry.bytes[2] = acc[15:8];
      q_entry.nbytes   = total[4:3];
      q_entry.tally    = tally_in;
      q_push           = accept && kind_ok && (total[4:3] != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
         cur_oct_ff <= '0;
         known_ff   <= 1'b0;
         tally_ff   <= '0;
      end else if (accept && kind_ok) begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
         cur_oct_ff <= cur_oct_in;
         known_ff   <= known_in;
         tally_ff   <= tally_in;
      end
   end

endmodule

// ----- hdl/rnbp_queue.sv -----
// ----------------------------------------------------------------------------
// Ringtone note bit packer queue
// Short first-in first-out store of byte groups between front and back.
// ----------------------------------------------------------------------------
module rnbp_queue import rnbp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rnbp_entry_type push_entry,
   input  logic           pop,
   output rnbp_entry_type head,
   output logic           full,
   output logic           empty
);

   rnbp_entry_type slots_ff [QueueDepth];

   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == (QueuePtrW + 1)'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QueuePtrW + 1)'(do_push) - (QueuePtrW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/rnbp_back.sv -----
// ----------------------------------------------------------------------------
// Ringtone note bit packer back end
// Sends the bytes of each queue entry one at a time through an output
// register and marks the final byte of each transaction.
// ----------------------------------------------------------------------------
module rnbp_back import rnbp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  rnbp_entry_type head,
   input  logic           q_empty,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last,
   output logic [7:0]     rsp_instruction_count
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [7:0] count_ff, count_in;
   logic       load;
   logic       at_end;

   always_comb begin
      load     = !q_empty && (!valid_ff || rsp_ready);
      at_end   = (idx_ff == head.nbytes - 2'd1);
      q_pop    = load && at_end;
      idx_in   = load ? (at_end ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      valid_in = load || (valid_ff && !rsp_ready);
      byte_in  = head.bytes[idx_ff];
      last_in  = at_end;
      count_in = head.tally;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_out_byte          = byte_ff;
   assign rsp_last              = last_ff;
   assign rsp_instruction_count = count_ff;

endmodule

// ----- hdl/ringtone_note_bit_packer.sv -----
// ----------------------------------------------------------------------------
// Ringtone note bit packer
// Packs start, note and finish transactions into an MSB-first byte stream.
// ----------------------------------------------------------------------------
// The front end takes one request transaction per clock cycle while its
// four-entry queue has room, and each transaction leaves on the response
// side as the bytes it completes, one byte per cycle while rsp_ready is
// high, through an output register: a start gives two or three bytes, a
// note one to three and a finish one or two, so an item takes one to three
// bytes of the byte-wide output and that output sets the sustained rate.
// The first byte of an item passes through a queue slot and then the
// output register before it is offered on the response port. The tempo
// code is derived when tempo_bpm is written, and configuration is to be
// written only while no transaction is in flight.
module ringtone_note_bit_packer import rnbp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [2:0] req_note_letter,
   input  logic       req_sharp,
   input  logic       req_duration_given,
   input  logic [5:0] req_duration,
   input  logic       req_octave_given,
   input  logic [2:0] req_octave,
   input  logic       req_dotted,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic [7:0] rsp_instruction_count
);

   rnbp_entry_type push_entry;
   rnbp_entry_type head;
   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_empty;

   rnbp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_note_letter    (req_note_letter),
      .req_sharp          (req_sharp),
      .req_duration_given (req_duration_given),
      .req_duration       (req_duration),
      .req_octave_given   (req_octave_given),
      .req_octave         (req_octave),
      .req_dotted         (req_dotted),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (push_entry)
   );

   rnbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   rnbp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (head),
      .q_empty               (q_empty),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_last              (rsp_last),
      .rsp_instruction_count (rsp_instruction_count)
   );

   // The remaining bytes of a transaction sit at the queue head, so the next
   // one follows at once.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("response gap inside a transaction");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_instruction_count == $past(rsp_instruction_count)))
      else $error("instruction count changed inside a transaction");

   assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue both full and empty");

endmodule
